// ===== design/lanczos_line_resampler_core_macros.svh =====
// ----------------------------------------------------------------------------
// Lanczos line resampler: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LANCZOS_LINE_RESAMPLER_CORE_MACROS_SVH
`define LANCZOS_LINE_RESAMPLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/llr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lanczos line resampler package
// Field widths, fixed-point constants, codes and shared types.
// ----------------------------------------------------------------------------
package llr_pkg;

    // Default sizes of the stores.
    localparam int LINE_DEPTH_DEF = 1024;
    localparam int OUT_DEPTH_DEF  = 1024;
    localparam int MAX_TAPS_DEF   = 32;

    // Field widths.
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 15;
    localparam int SAMPLE_W = 8;
    localparam int COEF_W   = 24;
    localparam int START_W  = 10;
    localparam int CNT_W    = 6;
    localparam int POS_W    = 10;
    localparam int PIXEL_W  = 8;
    localparam int TPP_W    = 6;

    // Fixed-point arithmetic.
    localparam int ACC_W     = 32;
    localparam int FRAC_BITS = 32 - 8 - 2;
    localparam int PIXEL_MAX = 255;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [TPP_W-1:0] TPP_RESET = 6'd7;
    localparam logic REG_TPP = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE  = 2'd0,
        FUNC_COEF    = 2'd1,
        FUNC_BOUNDS  = 2'd2,
        FUNC_COMPUTE = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_BOUNDS = 4'b0010,
        S_TAPS   = 4'b0100,
        S_DRAIN  = 4'b1000
    } t_state;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic tap_v;
    } t_mac_ctl;

endpackage

// ===== design/lanczos_line_resampler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lanczos line resampler core
// One-dimensional polyphase resampler over one line of 8-bit samples.
// ----------------------------------------------------------------------------
// The block holds a line of source samples, a coefficient bank with
// taps_per_position slots per output position, and a start/tap-count pair
// per output position, all in single-port synchronous RAMs. Load transfers
// (write sample, write coefficient, write bounds) are written straight into
// their RAM at the transfer, so loads can stream back to back. A compute
// transfer for position p first reads the bounds, then walks the taps at one
// sample read and one coefficient read per cycle, feeds a registered 8x24
// multiplier and a 32-bit accumulator that starts at one half LSB (2^21),
// and finally shifts the sum right by 22 bits and clamps it to 0..255. A
// compute transfer keeps the input stalled through the bounds read, the tap
// walk and the drain of the multiply and accumulate stages, so the next
// transfer is taken only after its result has been loaded; the tap walk
// runs through the two RAM read ports. Results sit in an output register,
// so a compute may start while the previous result still waits on
// o_out_valid; it only waits at its end if that register is still full.
// Write and compute transfers whose index lies beyond their store are
// taken and dropped without a result. Taps that would fall past the sample
// line or the coefficient bank add nothing.
// taps_per_position is written through the APB port at byte address 0; a
// value of 0 acts as 1 and a value above MAX_TAPS acts as MAX_TAPS. Write it
// only while the block is idle.
// ----------------------------------------------------------------------------
module lanczos_line_resampler_core
    import llr_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF,
    parameter int OUT_DEPTH  = OUT_DEPTH_DEF,
    parameter int MAX_TAPS   = MAX_TAPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic [IDX_W-1:0]         i_index,
    input  logic [SAMPLE_W-1:0]      i_sample_value,
    input  logic signed [COEF_W-1:0] i_coefficient,
    input  logic [START_W-1:0]       i_first_source,
    input  logic [CNT_W-1:0]         i_tap_count,
    // Output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [POS_W-1:0]         o_position,
    output logic [PIXEL_W-1:0]       o_pixel,
    // Configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    localparam int COEF_DEPTH = OUT_DEPTH * MAX_TAPS;
    localparam int SAW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int OAW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CAW = $clog2(COEF_DEPTH);
    // Coefficient slot and sample index of a tap may run past their store.
    localparam int CIW = CAW + 1;
    localparam int SIW = (SAW >= START_W) ? SAW + 1 : START_W + 1;
    localparam int TCW = $clog2(MAX_TAPS + 1);
    localparam int BW  = START_W + CNT_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [TPP_W-1:0] r_tpp;
    logic [TPP_W-1:0] n_tpp;
    logic             cfg_wr;
    logic [TCW-1:0]   tpp_eff;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TPP);
    assign n_tpp  = cfg_wr ? pwdata[TPP_W-1:0] : r_tpp;
    assign prdata = (paddr[2] == REG_TPP) ? PDATA_W'(r_tpp) : '0;

    always_comb begin
        if (r_tpp == '0) begin
            tpp_eff = TCW'(1);
        end else if (32'(r_tpp) > MAX_TAPS) begin
            tpp_eff = TCW'(MAX_TAPS);
        end else begin
            tpp_eff = TCW'(r_tpp);
        end
    end

    // ------------------------------------------------------------------
    // Input decode. Loads write their RAM at the transfer edge.
    // ------------------------------------------------------------------
    t_state         r_state;
    t_state         n_state;
    logic           in_xfer;
    logic [31:0]    idx32;
    logic           we_sample;
    logic           we_coef;
    logic           we_bounds;
    logic           start_compute;

    assign o_in_stall    = (r_state != S_IDLE);
    assign in_xfer       = i_in_valid && !o_in_stall;
    assign idx32         = 32'(i_index);
    assign we_sample     = in_xfer && (i_func == FUNC_SAMPLE) && (idx32 < LINE_DEPTH);
    assign we_coef       = in_xfer && (i_func == FUNC_COEF) && (idx32 < COEF_DEPTH);
    assign we_bounds     = in_xfer && (i_func == FUNC_BOUNDS) && (idx32 < OUT_DEPTH);
    assign start_compute = in_xfer && (i_func == FUNC_COMPUTE) && (idx32 < OUT_DEPTH);

    // ------------------------------------------------------------------
    // Tap walk
    // ------------------------------------------------------------------
    logic [START_W-1:0] r_start;
    logic [START_W-1:0] n_start;
    logic [TCW-1:0]     r_count;
    logic [TCW-1:0]     n_count;
    logic [TCW-1:0]     r_tap;
    logic [TCW-1:0]     n_tap;
    logic [CIW-1:0]     r_coef_base;
    logic [CIW-1:0]     n_coef_base;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic               r_issue_v;
    logic               n_issue_v;
    logic [SIW-1:0]     tap_si;
    logic [CIW-1:0]     tap_ci;
    logic               tap_go;
    logic               tap_ok;
    logic [BW-1:0]      bounds_rdata;
    logic [CNT_W-1:0]   stored_count;

    assign tap_si = SIW'(r_start) + SIW'(r_tap);
    assign tap_ci = r_coef_base + CIW'(r_tap);
    assign tap_go = (r_state == S_TAPS) && (r_tap != r_count);
    assign tap_ok = tap_go && (32'(tap_si) < LINE_DEPTH) && (32'(tap_ci) < COEF_DEPTH);
    assign stored_count = bounds_rdata[CNT_W-1:0];

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    logic [SAW-1:0]      sample_addr;
    logic [CAW-1:0]      coef_addr;
    logic [SAMPLE_W-1:0] sample_rdata;
    logic [COEF_W-1:0]   coef_rdata;

    assign sample_addr = (r_state == S_TAPS) ? tap_si[SAW-1:0] : idx32[SAW-1:0];
    assign coef_addr   = (r_state == S_TAPS) ? tap_ci[CAW-1:0] : idx32[CAW-1:0];

    llr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH),
        .AW    (SAW)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (we_sample),
        .i_addr  (sample_addr),
        .i_wdata (i_sample_value),
        .o_rdata (sample_rdata)
    );

    llr_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH),
        .AW    (CAW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (we_coef),
        .i_addr  (coef_addr),
        .i_wdata (i_coefficient),
        .o_rdata (coef_rdata)
    );

    // Start and tap count share one word per output position.
    llr_ram #(
        .WIDTH (BW),
        .DEPTH (OUT_DEPTH),
        .AW    (OAW)
    ) u_bounds_ram (
        .i_clk   (i_clk),
        .i_we    (we_bounds),
        .i_addr  (idx32[OAW-1:0]),
        .i_wdata ({i_first_source, i_tap_count}),
        .o_rdata (bounds_rdata)
    );

    // ------------------------------------------------------------------
    // Multiply-accumulate
    // ------------------------------------------------------------------
    t_mac_ctl           mac_ctl;
    logic               mac_busy;
    logic [PIXEL_W-1:0] mac_pixel;

    assign mac_ctl = '{clear: start_compute, tap_v: r_issue_v};

    llr_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_sample (sample_rdata),
        .i_coef   ($signed(coef_rdata)),
        .o_busy   (mac_busy),
        .o_pixel  (mac_pixel)
    );

    // ------------------------------------------------------------------
    // Sequencer and output register
    // ------------------------------------------------------------------
    logic               r_out_valid;
    logic               n_out_valid;
    logic [POS_W-1:0]   r_out_pos;
    logic [PIXEL_W-1:0] r_out_pixel;
    logic               out_free;
    logic               out_load;

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_DRAIN) && !r_issue_v && !mac_busy && out_free;

    always_comb begin
        n_state     = r_state;
        n_start     = r_start;
        n_count     = r_count;
        n_tap       = r_tap;
        n_coef_base = r_coef_base;
        n_pos       = r_pos;
        n_issue_v   = tap_ok;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (start_compute) begin
                    n_pos       = i_index[POS_W-1:0];
                    n_coef_base = CIW'(idx32[OAW-1:0]) * CIW'(tpp_eff);
                    n_state     = S_BOUNDS;
                end
            end
            S_BOUNDS: begin
                n_start = bounds_rdata[BW-1:CNT_W];
                if (32'(stored_count) > MAX_TAPS) begin
                    n_count = TCW'(MAX_TAPS);
                end else begin
                    n_count = TCW'(stored_count);
                end
                n_tap   = '0;
                n_state = S_TAPS;
            end
            S_TAPS: begin
                if (tap_go) begin
                    n_tap = r_tap + TCW'(1);
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue_v   <= 1'b0;
            r_out_valid <= 1'b0;
            r_tpp       <= TPP_RESET;
        end else begin
            r_state     <= n_state;
            r_issue_v   <= n_issue_v;
            r_out_valid <= n_out_valid;
            r_tpp       <= n_tpp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_count     <= n_count;
        r_tap       <= n_tap;
        r_coef_base <= n_coef_base;
        r_pos       <= n_pos;
        if (out_load) begin
            r_out_pos   <= r_pos;
            r_out_pixel <= mac_pixel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_out_pos;
    assign o_pixel     = r_out_pixel;

endmodule

// ===== design/llr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lanczos line resampler: generic RAM
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module llr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/llr_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lanczos line resampler: multiply-accumulate unit
// Registered sample-by-coefficient product, 32-bit wrapping accumulator and
// the final shift and clamp to a pixel.
// ----------------------------------------------------------------------------
module llr_mac
    import llr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic [SAMPLE_W-1:0]      i_sample,
    input  logic signed [COEF_W-1:0] i_coef,
    output logic                     o_busy,
    output logic [PIXEL_W-1:0]       o_pixel
);

    localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (FRAC_BITS - 1);
    localparam int HI = FRAC_BITS + PIXEL_W;

    logic signed [ACC_W-1:0] w_sample;
    logic signed [ACC_W-1:0] w_coef;
    logic signed [ACC_W-1:0] n_prod;
    logic signed [ACC_W-1:0] r_prod;
    logic                    r_prod_v;
    logic [ACC_W-1:0]        r_acc;
    logic [ACC_W-1:0]        n_acc;

    assign w_sample = ACC_W'($signed({1'b0, i_sample}));
    assign w_coef   = ACC_W'(i_coef);
    assign n_prod   = w_sample * w_coef;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = ROUND;
        end else if (r_prod_v) begin
            n_acc = r_acc + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.tap_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    // A negative sum gives black; anything at or above 256 saturates to white.
    always_comb begin
        if (r_acc[ACC_W-1]) begin
            o_pixel = '0;
        end else if (|r_acc[ACC_W-2:HI]) begin
            o_pixel = PIXEL_W'(PIXEL_MAX);
        end else begin
            o_pixel = r_acc[HI-1:FRAC_BITS];
        end
    end

    assign o_busy = r_prod_v;

endmodule

// ===== design/llr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lanczos line resampler: port checker
// Watches the top-level ports for flow-control and sequencing slips.
// ----------------------------------------------------------------------------
`include "lanczos_line_resampler_core_macros.svh"

module llr_checker
    import llr_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [FUNC_W-1:0]  i_func,
    input logic [IDX_W-1:0]   i_index,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [POS_W-1:0]   o_position,
    input logic [PIXEL_W-1:0] o_pixel
);

    logic                     in_xfer;
    logic                     load_xfer;
    logic                     compute_xfer;
    logic                     out_held;
    logic [POS_W+PIXEL_W-1:0] out_word;

    assign in_xfer      = i_in_valid && !o_in_stall;
    assign load_xfer    = in_xfer && (i_func != FUNC_COMPUTE);
    assign compute_xfer = in_xfer && (i_func == FUNC_COMPUTE) && (32'(i_index) < OUT_DEPTH);
    assign out_held     = o_out_valid && i_out_stall;
    assign out_word     = {o_position, o_pixel};

    // A stalled result keeps its valid and its payload.
    `LLR_ASSERT_NEXT(a_out_hold, out_held, o_out_valid && $stable(out_word), "held result moved")

    // A load transfer leaves the block ready in the next cycle.
    `LLR_ASSERT_NEXT(a_load_single, load_xfer, !o_in_stall, "load transfer stalled the input")

    // An in-range compute transfer holds off the next input item.
    `LLR_ASSERT_NEXT(a_compute_busy, compute_xfer, o_in_stall, "compute did not stall the input")

    // A new result only appears at the end of a compute.
    `LLR_ASSERT_SAME(a_result_origin, $rose(o_out_valid), $past(o_in_stall), "result without a compute")

endmodule

bind lanczos_line_resampler_core llr_checker #(
    .OUT_DEPTH (OUT_DEPTH)
) u_llr_checker (.*);
